// ===== rtl/bfkn_pkg.sv =====
// ----------------------------------------------------------------------------
// bfkn_pkg
// Shared widths, codes and types for the band-filtered nearest-neighbour
// selector.
// ----------------------------------------------------------------------------
package bfkn_pkg;

  localparam int KEEP_CAPACITY   = 32;
  localparam int STATION_ID_BITS = 16;
  localparam int DIST_W          = 36;
  localparam int MAX_KEEP_W      = 6;
  localparam int CFG_DATA_W      = 36;
  localparam int CFG_IDX_W       = 2;

  localparam int CAP_W = (KEEP_CAPACITY > 1) ? $clog2(KEEP_CAPACITY) : 1;
  // kept count runs to KEEP_CAPACITY + 1
  localparam int CNT_W = $clog2(KEEP_CAPACITY + 2);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEEP = 2'd2;

  typedef enum logic [1:0] {
    KIND_REF,
    KIND_KEEP,
    KIND_DROP
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic                       last;
    logic [STATION_ID_BITS-1:0] id;
    logic [DIST_W-1:0]          dist_mm;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

endpackage

// ===== rtl/bfkn_front.sv =====
// ----------------------------------------------------------------------------
// bfkn_front
// Accepts station requests, holds the configuration and tags each item as
// reference, kept neighbour or dropped neighbour before queueing it.
// ----------------------------------------------------------------------------
module bfkn_front
  import bfkn_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [STATION_ID_BITS-1:0] in_station_id,
  input  logic [DIST_W-1:0]          in_distance_mm,
  input  logic                       in_last_item,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       q_full,
  output push_t                      push,
  output logic [MAX_KEEP_W-1:0]      max_keep
);

  logic [DIST_W-1:0]     min_dist_r;
  logic [DIST_W-1:0]     max_dist_r;
  logic [MAX_KEEP_W-1:0] max_keep_r;
  logic                  ref_pending_r;
  logic                  in_band;
  logic                  accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_band  = (in_distance_mm >= min_dist_r) && (in_distance_mm <= max_dist_r);

  always_comb begin
    push.valid        = accept;
    push.item.last    = in_last_item;
    push.item.id      = in_station_id;
    push.item.dist_mm = in_distance_mm;
    priority if (ref_pending_r) begin
      push.item.kind = KIND_REF;
    end else if (in_band) begin
      push.item.kind = KIND_KEEP;
    end else begin
      push.item.kind = KIND_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r    <= '0;
      max_dist_r    <= '1;
      max_keep_r    <= MAX_KEEP_W'(KEEP_CAPACITY);
      ref_pending_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MIN_DIST: min_dist_r <= cfg_wdata[DIST_W-1:0];
          CFG_MAX_DIST: max_dist_r <= cfg_wdata[DIST_W-1:0];
          CFG_MAX_KEEP: max_keep_r <= cfg_wdata[MAX_KEEP_W-1:0];
          default: ;
        endcase
      end
      // the item after a list's last one is the next reference
      if (accept) ref_pending_r <= in_last_item;
    end
  end

  assign max_keep = max_keep_r;

endmodule

// ===== rtl/bfkn_queue.sv =====
// ----------------------------------------------------------------------------
// bfkn_queue
// Short FIFO between the front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module bfkn_queue
  import bfkn_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output logic  q_full,
  output logic  q_valid,
  output item_t q_item
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign q_full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push.valid && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push.valid) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bfkn_back.sv =====
// ----------------------------------------------------------------------------
// bfkn_back
// Keeps neighbours in arrival order and in a compare-and-shift sorted list,
// then emits the reference and the chosen neighbours at end of list.
// ----------------------------------------------------------------------------
module bfkn_back
  import bfkn_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  item_t                      q_item,
  output logic                       pop,
  input  logic [MAX_KEEP_W-1:0]      max_keep,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATION_ID_BITS-1:0] out_station_id,
  output logic [DIST_W-1:0]          out_distance_mm,
  output logic                       out_last
);

  typedef enum logic {
    ST_RUN,
    ST_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           kept_r, kept_nxt;
  logic [STATION_ID_BITS-1:0] ref_id_r, ref_id_nxt;
  logic [CAP_W-1:0]           idx_r, idx_nxt;
  logic [CNT_W-1:0]           emit_r, emit_nxt;
  logic                       sorted_mode_r, sorted_mode_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [STATION_ID_BITS-1:0] out_id_r, out_id_nxt;
  logic [DIST_W-1:0]          out_dist_r, out_dist_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [STATION_ID_BITS-1:0] arr_id_r   [KEEP_CAPACITY];
  logic [DIST_W-1:0]          arr_dist_r [KEEP_CAPACITY];
  logic [STATION_ID_BITS-1:0] srt_id_r   [KEEP_CAPACITY];
  logic [DIST_W-1:0]          srt_dist_r [KEEP_CAPACITY];

  logic                     slot_free;
  logic                     do_insert;
  logic                     do_shift;
  logic                     fin;
  logic [CNT_W-1:0]         kept_after;
  logic [CNT_W-1:0]         limit;
  logic [CNT_W-1:0]         emit_n;
  logic [KEEP_CAPACITY-1:0] ins;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = (state_r == ST_RUN) && q_valid && (!q_item.last || slot_free);
  assign do_insert = pop && (q_item.kind == KIND_KEEP);
  assign do_shift  = (state_r == ST_EMIT) && slot_free && sorted_mode_r;
  assign fin       = ((CNT_W'(idx_r) + CNT_W'(1)) == emit_r);

  always_comb begin
    if (max_keep == '0) begin
      limit = CNT_W'(1);
    end else if (int'(max_keep) > KEEP_CAPACITY) begin
      limit = CNT_W'(KEEP_CAPACITY);
    end else begin
      limit = CNT_W'(max_keep);
    end
  end

  always_comb begin
    unique case (q_item.kind)
      KIND_REF:  kept_after = '0;
      KIND_KEEP: kept_after = (kept_r < CNT_W'(KEEP_CAPACITY + 1)) ? kept_r + 1'b1 : kept_r;
      default:   kept_after = kept_r;
    endcase
    emit_n = (kept_after <= limit) ? kept_after : limit;
  end

  // insertion point: first held cell whose distance is strictly greater, else the first free cell
  always_comb begin
    for (int j = 0; j < KEEP_CAPACITY; j++) begin
      ins[j] = !((CNT_W'(j) < kept_r) && (srt_dist_r[j] <= q_item.dist_mm));
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int j = 0; j < KEEP_CAPACITY; j++) begin
        if (ins[j]) begin
          if (j == 0 || !ins[(j == 0) ? 0 : j - 1]) begin
            srt_id_r[j]   <= q_item.id;
            srt_dist_r[j] <= q_item.dist_mm;
          end else begin
            srt_id_r[j]   <= srt_id_r[(j == 0) ? 0 : j - 1];
            srt_dist_r[j] <= srt_dist_r[(j == 0) ? 0 : j - 1];
          end
        end
      end
    end else if (do_shift) begin
      for (int j = 0; j < KEEP_CAPACITY - 1; j++) begin
        srt_id_r[j]   <= srt_id_r[j + 1];
        srt_dist_r[j] <= srt_dist_r[j + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert && (kept_r < CNT_W'(KEEP_CAPACITY))) begin
      arr_id_r[kept_r[CAP_W-1:0]]   <= q_item.id;
      arr_dist_r[kept_r[CAP_W-1:0]] <= q_item.dist_mm;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    kept_nxt        = kept_r;
    ref_id_nxt      = ref_id_r;
    idx_nxt         = idx_r;
    emit_nxt        = emit_r;
    sorted_mode_nxt = sorted_mode_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_id_nxt      = out_id_r;
    out_dist_nxt    = out_dist_r;
    out_last_nxt    = out_last_r;
    unique case (state_r)
      ST_RUN: begin
        if (pop) begin
          kept_nxt = kept_after;
          if (q_item.kind == KIND_REF) ref_id_nxt = q_item.id;
          if (q_item.last) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = (q_item.kind == KIND_REF) ? q_item.id : ref_id_r;
            out_dist_nxt  = '0;
            out_last_nxt  = (emit_n == '0);
            kept_nxt      = '0;
            if (emit_n != '0) begin
              state_nxt       = ST_EMIT;
              idx_nxt         = '0;
              emit_nxt        = emit_n;
              sorted_mode_nxt = (kept_after > limit);
            end
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = sorted_mode_r ? srt_id_r[0]   : arr_id_r[idx_r];
          out_dist_nxt  = sorted_mode_r ? srt_dist_r[0] : arr_dist_r[idx_r];
          out_last_nxt  = fin;
          idx_nxt       = idx_r + 1'b1;
          if (fin) state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_RUN;
      kept_r        <= '0;
      ref_id_r      <= '0;
      idx_r         <= '0;
      emit_r        <= '0;
      sorted_mode_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      kept_r        <= kept_nxt;
      ref_id_r      <= ref_id_nxt;
      idx_r         <= idx_nxt;
      emit_r        <= emit_nxt;
      sorted_mode_r <= sorted_mode_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_id_r   <= out_id_nxt;
    out_dist_r <= out_dist_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_station_id  = out_id_r;
  assign out_distance_mm = out_dist_r;
  assign out_last        = out_last_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ((CNT_W'(idx_r) < emit_r) && (emit_r != '0)))
    else $error("emission index past emit count");

  a_kept_sat: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= CNT_W'(KEEP_CAPACITY + 1))
    else $error("kept count beyond saturation");

  a_sorted_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && sorted_mode_r) |-> (emit_r == limit))
    else $error("sorted emission shorter than limit");

  a_enter_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_item.last && (emit_n != '0)) |=> ((state_r == ST_EMIT) && out_valid_r))
    else $error("end of list did not start emission");

  a_ref_no_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_item.last && (emit_n == '0)) |=> (out_valid_r && out_last_r))
    else $error("lone reference not marked last");

endmodule

// ===== rtl/band_filter_k_nearest_select_unit.sv =====
// ----------------------------------------------------------------------------
// band_filter_k_nearest_select_unit
// Band-filtered k-nearest neighbour selector, top level.
// ----------------------------------------------------------------------------
// Input requests carry a station id, a distance and a last flag. The first
// request of a list is the reference; later ones are neighbours, dropped
// when outside [min_distance_mm, max_distance_mm]. On the last request the
// block emits the reference (distance 0), then either every kept neighbour
// in arrival order or, when more were kept than max_keep clamped to
// 1..KEEP_CAPACITY, that many nearest in ascending distance, ties in arrival
// order. out_last marks the final result of a list.
// While a list streams in, one input request is taken per cycle unless the
// queue is full; the sorted list inserts a neighbour per cycle by a parallel
// compare and shift over all KEEP_CAPACITY cells. At end of list the emit
// sequencer gives one result per cycle while out_stall is low, and holds
// off the next list meanwhile (the two-entry queue still takes requests
// until full). The reference result passes the queue and the output register.
// Reset (synchronous, rst_n low) restores the register defaults and empties
// the queue; the next request is a reference. A stalled result holds in the
// output register while the front keeps accepting into the queue.
// ----------------------------------------------------------------------------
module band_filter_k_nearest_select_unit
  import bfkn_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [STATION_ID_BITS-1:0] in_station_id,
  input  logic [DIST_W-1:0]          in_distance_mm,
  input  logic                       in_last_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATION_ID_BITS-1:0] out_station_id,
  output logic [DIST_W-1:0]          out_distance_mm,
  output logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  push_t                 push;
  logic                  q_full;
  logic                  q_valid;
  item_t                 q_item;
  logic                  pop;
  logic [MAX_KEEP_W-1:0] max_keep;

  bfkn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_station_id  (in_station_id),
    .in_distance_mm (in_distance_mm),
    .in_last_item   (in_last_item),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .q_full         (q_full),
    .push           (push),
    .max_keep       (max_keep)
  );

  bfkn_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (pop),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  bfkn_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .max_keep        (max_keep),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_station_id  (out_station_id),
    .out_distance_mm (out_distance_mm),
    .out_last        (out_last)
  );

endmodule

// ===== test/tb_band_filter_k_nearest_select_unit.sv =====
// ----------------------------------------------------------------------------
// tb_band_filter_k_nearest_select_unit
// Self-checking bench for the band-filtered nearest-neighbour selector.
// A short table of directed lists runs first, then random lists under a
// series of band and keep-limit settings. Every accepted request is run
// through a local model of the selector, and each result leaving the block
// is compared with the oldest predicted station. The input idles and the
// output stalls at random, and the output is once held off long enough to
// fill the block.
// ----------------------------------------------------------------------------
module tb_band_filter_k_nearest_select_unit;
  import bfkn_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 270;
  localparam int PHASE_ITEMS   = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};

  typedef struct packed {
    logic [STATION_ID_BITS-1:0] id;
    logic [DIST_W-1:0]          dist_mm;
    logic                       last;
  } station_rec_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } drill_kind_t;

  typedef struct packed {
    drill_kind_t                kind;
    logic [CFG_IDX_W-1:0]       reg_idx;
    logic [CFG_DATA_W-1:0]      value;   // register data, or request distance
    logic [STATION_ID_BITS-1:0] id;
    logic                       last;
    logic                       typed;   // single result typed in below
    logic [STATION_ID_BITS-1:0] want_id;
  } drill_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [STATION_ID_BITS-1:0] in_station_id;
  logic [DIST_W-1:0]          in_distance_mm;
  logic                       in_last_item;
  logic                       out_valid;
  logic                       out_stall;
  logic [STATION_ID_BITS-1:0] out_station_id;
  logic [DIST_W-1:0]          out_distance_mm;
  logic                       out_last;
  logic                       cfg_wr_en;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;

  band_filter_k_nearest_select_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_station_id   (in_station_id),
    .in_distance_mm  (in_distance_mm),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_station_id  (out_station_id),
    .out_distance_mm (out_distance_mm),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  logic [DIST_W-1:0]          band_lo;
  logic [DIST_W-1:0]          band_hi;
  logic [MAX_KEEP_W-1:0]      keep_limit;
  bit                         awaiting_ref;
  logic [STATION_ID_BITS-1:0] ref_station;
  int                         kept_n;
  logic [STATION_ID_BITS-1:0] by_arrival_id   [KEEP_CAPACITY];
  logic [DIST_W-1:0]          by_arrival_dist [KEEP_CAPACITY];
  logic [STATION_ID_BITS-1:0] by_rank_id      [KEEP_CAPACITY];
  logic [DIST_W-1:0]          by_rank_dist    [KEEP_CAPACITY];

  station_rec_t selected_stations[$];
  drill_row_t   drill[$];

  int requests_taken = 0;
  int fail_count     = 0;
  int cycle_count    = 0;
  bit gapless        = 1'b0;

  // stable insertion into the ranked list, plus arrival log
  function automatic void keep_station(logic [STATION_ID_BITS-1:0] id,
                                       logic [DIST_W-1:0] dist_mm);
    int held;
    int pos;
    int j;
    held = (kept_n < KEEP_CAPACITY) ? kept_n : KEEP_CAPACITY;
    pos  = 0;
    if (kept_n < KEEP_CAPACITY) begin
      by_arrival_id[kept_n]   = id;
      by_arrival_dist[kept_n] = dist_mm;
    end
    while (pos < held && by_rank_dist[pos] <= dist_mm) pos++;
    if (pos < KEEP_CAPACITY) begin
      j = (held < KEEP_CAPACITY) ? held : KEEP_CAPACITY - 1;
      while (j > pos) begin
        by_rank_id[j]   = by_rank_id[j-1];
        by_rank_dist[j] = by_rank_dist[j-1];
        j--;
      end
      by_rank_id[pos]   = id;
      by_rank_dist[pos] = dist_mm;
    end
    if (kept_n < KEEP_CAPACITY + 1) kept_n++;
  endfunction

  function automatic void select_neighbours(logic [STATION_ID_BITS-1:0] id,
                                            logic [DIST_W-1:0] dist_mm,
                                            logic last, bit log_results);
    int lim;
    int emit;
    station_rec_t rec;
    if (awaiting_ref) begin
      ref_station  = id;
      kept_n       = 0;
      awaiting_ref = 1'b0;
    end else if (dist_mm >= band_lo && dist_mm <= band_hi) begin
      keep_station(id, dist_mm);
    end
    if (last) begin
      lim = int'(keep_limit);
      if (lim < 1) lim = 1;
      if (lim > KEEP_CAPACITY) lim = KEEP_CAPACITY;
      emit = (kept_n <= lim) ? kept_n : lim;
      rec = '{id: ref_station, dist_mm: '0, last: (emit == 0)};
      if (log_results) selected_stations.push_back(rec);
      for (int i = 0; i < emit; i++) begin
        if (kept_n <= lim) begin
          rec.id      = by_arrival_id[i];
          rec.dist_mm = by_arrival_dist[i];
        end else begin
          rec.id      = by_rank_id[i];
          rec.dist_mm = by_rank_dist[i];
        end
        rec.last = (i + 1 == emit);
        if (log_results) selected_stations.push_back(rec);
      end
      awaiting_ref = 1'b1;
      kept_n       = 0;
    end
  endfunction

  function automatic logic [DIST_W-1:0] rand36();
    logic [3:0]  top;
    logic [31:0] low;
    top = 4'($urandom_range(15, 0));
    low = $urandom;
    return {top, low};
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance();
    int          r;
    logic [63:0] span;
    r = $urandom_range(99, 0);
    if (r < 30) return rand36();
    // around the band edges, wrapping at 36 bits
    if (r < 42) return band_lo + 36'($urandom_range(4, 0)) - 36'd2;
    if (r < 55) return band_hi + 36'($urandom_range(4, 0)) - 36'd2;
    // a narrow cluster gives plenty of equal distances
    if (r < 80) return band_lo + 36'($urandom_range(7, 0));
    if (band_hi < band_lo) return rand36();
    span = 64'(band_hi - band_lo) + 64'd1;
    return band_lo + 36'(64'(rand36()) % span);
  endfunction

  function automatic int pick_gap();
    int r;
    if (gapless) return 0;
    r = $urandom_range(99, 0);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic int pick_list_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return $urandom_range(6, 0);
    if (r < 85) return $urandom_range(20, 7);
    return $urandom_range(40, 30);   // around and past capacity, where the count saturates
  endfunction

  function automatic drill_row_t req_row(logic [STATION_ID_BITS-1:0] id,
                                         logic [DIST_W-1:0] dist_mm, logic last);
    return '{kind: ROW_REQ, reg_idx: '0, value: dist_mm, id: id, last: last,
             typed: 1'b0, want_id: '0};
  endfunction

  // a request whose only result is the bare reference
  function automatic drill_row_t req_row_typed(logic [STATION_ID_BITS-1:0] id,
                                               logic [DIST_W-1:0] dist_mm,
                                               logic [STATION_ID_BITS-1:0] want_id);
    return '{kind: ROW_REQ, reg_idx: '0, value: dist_mm, id: id, last: 1'b1,
             typed: 1'b1, want_id: want_id};
  endfunction

  function automatic drill_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    return '{kind: ROW_CFG, reg_idx: idx, value: data, id: '0, last: 1'b0,
             typed: 1'b0, want_id: '0};
  endfunction

  task automatic send_request(input logic [STATION_ID_BITS-1:0] id,
                              input logic [DIST_W-1:0] dist_mm, input logic last,
                              input logic typed,
                              input logic [STATION_ID_BITS-1:0] want_id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_station_id  <= id;
    in_distance_mm <= dist_mm;
    in_last_item   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_taken++;
    select_neighbours(id, dist_mm, last, !typed);
    if (typed) selected_stations.push_back(station_rec_t'{want_id, '0, 1'b1});
  endtask

  // only called with the list closed; waits for the block to drain
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (selected_stations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_MIN_DIST: band_lo    = data[DIST_W-1:0];
      CFG_MAX_DIST: band_hi    = data[DIST_W-1:0];
      CFG_MAX_KEEP: keep_limit = data[MAX_KEEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure_phase(input int phase);
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    logic [DIST_W-1:0] swap;
    int                keep;
    lo = rand36();
    hi = rand36();
    if (lo > hi) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    keep = $urandom_range(63, 0);
    case (phase)
      0: begin lo = '0; hi = DIST_ALL_ONES; keep = KEEP_CAPACITY; end
      1: begin lo = '0; hi = DIST_ALL_ONES; keep = 1; end
      2: begin lo = '0; hi = DIST_ALL_ONES; keep = 0; end
      3: begin hi = DIST_ALL_ONES; keep = 63; end
      4: begin hi = lo; keep = KEEP_CAPACITY + 1; end
      5: begin
        swap = lo;   // inverted band
        lo   = hi + 36'd1;
        hi   = swap;
      end
      6: keep = $urandom_range(8, 2);
      default: ;
    endcase
    write_register(CFG_MIN_DIST, lo);
    write_register(CFG_MAX_DIST, hi);
    write_register(CFG_MAX_KEEP, CFG_DATA_W'(keep));
  endtask

  task automatic run_list(input int neighbours);
    gapless = ($urandom_range(3, 0) == 0);
    send_request(16'($urandom), rand36(), neighbours == 0, 1'b0, '0);
    for (int i = 0; i < neighbours; i++)
      send_request(16'($urandom), pick_distance(), i == neighbours - 1, 1'b0, '0);
  endtask

  // receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int  run;
    int  calm;
    int  r;
    bit  squeezed;
    run       = 0;
    calm      = 0;
    squeezed  = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!squeezed && requests_taken >= 120) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else if (calm > 0) begin
        calm--;
        out_stall <= 1'b0;
      end else if (run > 0) begin
        run--;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 3) calm = $urandom_range(150, 40);
        else if (r < 28) run = $urandom_range(2, 0);
        else if (r < 31) run = $urandom_range(40, 10);
        out_stall <= (r >= 3 && r < 31);
      end
    end
  end

  always @(posedge clk) begin : result_check
    station_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (selected_stations.size() == 0) begin
        $error("unexpected result: out_station_id %h out_distance_mm %h",
               out_station_id, out_distance_mm);
        fail_count++;
      end else begin
        want = selected_stations.pop_front();
        if (out_station_id !== want.id) begin
          $error("out_station_id: expected %h, got %h", want.id, out_station_id);
          fail_count++;
        end
        if (out_distance_mm !== want.dist_mm) begin
          $error("out_distance_mm: expected %h, got %h", want.dist_mm, out_distance_mm);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    int target;
    int phase_end;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_station_id  = '0;
    in_distance_mm = '0;
    in_last_item   = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    band_lo        = '0;
    band_hi        = DIST_ALL_ONES;
    keep_limit     = MAX_KEEP_W'(KEEP_CAPACITY);
    awaiting_ref   = 1'b1;
    ref_station    = '0;
    kept_n         = 0;

    // reference alone at both id extremes
    drill.push_back(req_row_typed(16'h0000, 36'h0_0000_0000, 16'h0000));
    drill.push_back(req_row_typed(16'hFFFF, DIST_ALL_ONES, 16'hFFFF));
    // distance extremes, all kept, arrival order
    drill.push_back(req_row(16'h1234, 36'd0, 1'b0));
    drill.push_back(req_row(16'hFFFF, 36'd0, 1'b0));
    drill.push_back(req_row(16'h0000, DIST_ALL_ONES, 1'b0));
    drill.push_back(req_row(16'h00A5, 36'd5, 1'b1));
    // keep one: nearest selected
    drill.push_back(cfg_row(CFG_MAX_KEEP, 36'd1));
    drill.push_back(req_row(16'h0101, 36'd0, 1'b0));
    drill.push_back(req_row(16'h0202, 36'd10, 1'b0));
    drill.push_back(req_row(16'h0303, 36'd5, 1'b1));
    // keep zero behaves as one; equal distances keep arrival order
    drill.push_back(cfg_row(CFG_MAX_KEEP, 36'd0));
    drill.push_back(req_row(16'h0404, 36'd0, 1'b0));
    drill.push_back(req_row(16'h0505, 36'd7, 1'b0));
    drill.push_back(req_row(16'h0606, 36'd7, 1'b1));
    // keep above capacity, band edges inclusive
    drill.push_back(cfg_row(CFG_MAX_KEEP, 36'd63));
    drill.push_back(cfg_row(CFG_MIN_DIST, 36'd100));
    drill.push_back(cfg_row(CFG_MAX_DIST, 36'd200));
    drill.push_back(req_row(16'h0707, 36'd0, 1'b0));
    drill.push_back(req_row(16'h1001, 36'd99, 1'b0));
    drill.push_back(req_row(16'h1002, 36'd100, 1'b0));
    drill.push_back(req_row(16'h1003, 36'd200, 1'b0));
    drill.push_back(req_row(16'h1004, 36'd201, 1'b1));
    // inverted band drops everything
    drill.push_back(cfg_row(CFG_MIN_DIST, 36'd300));
    drill.push_back(req_row(16'h0808, 36'd0, 1'b0));
    drill.push_back(req_row_typed(16'h0909, 36'd250, 16'h0808));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (drill[k]) begin
      if (drill[k].kind == ROW_CFG) begin
        write_register(drill[k].reg_idx, drill[k].value);
      end else begin
        send_request(drill[k].id, drill[k].value[DIST_W-1:0], drill[k].last,
                     drill[k].typed, drill[k].want_id);
      end
    end

    phase  = 0;
    target = requests_taken + RANDOM_ITEMS;
    while (requests_taken < target) begin
      configure_phase(phase);
      phase_end = requests_taken + PHASE_ITEMS;
      while (requests_taken < phase_end) run_list(pick_list_len());
      phase++;
    end

    in_valid <= 1'b0;
    while (selected_stations.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bfkn_pkg.sv
rtl/bfkn_front.sv
rtl/bfkn_queue.sv
rtl/bfkn_back.sv
rtl/band_filter_k_nearest_select_unit.sv
test/tb_band_filter_k_nearest_select_unit.sv
